// ----- hdl/y2r_pkg.sv -----
// ----------------------------------------------------------------------------
// y2r_pkg: shared types and constants for the 4:2:2 pair to RGB888 converter
// Holds the beat payload structs, the per-stage enable group and the fixed
// chroma coefficients split into quotient and remainder parts.
// ----------------------------------------------------------------------------
package y2r_pkg;

	// One input beat: a packed 4:2:2 group.
	typedef struct packed {
		logic [7:0]        luma_first;
		logic signed [7:0] chroma_blue;
		logic [7:0]        luma_second;
		logic signed [7:0] chroma_red;
		logic              second_present;
	} pair_t;

	// One output beat: two RGB888 pixels and the second pixel flag.
	typedef struct packed {
		logic [7:0] red_first;
		logic [7:0] green_first;
		logic [7:0] blue_first;
		logic [7:0] red_second;
		logic [7:0] green_second;
		logic [7:0] blue_second;
		logic       second_valid;
	} pixels_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// Chroma term width: magnitude stays below 2^24, plus sign.
	localparam int TERM_W = 26;

	typedef struct packed {
		logic signed [TERM_W-1:0] v_to_r;
		logic signed [TERM_W-1:0] u_to_g;
		logic signed [TERM_W-1:0] v_to_g;
		logic signed [TERM_W-1:0] u_to_b;
	} terms_t;

	// Pipeline advance strobes, one per stage.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

	typedef enum logic [1:0] {
		COEF_V_TO_R,
		COEF_U_TO_G,
		COEF_V_TO_G,
		COEF_U_TO_B
	} coef_t;

	// Coefficient magnitudes scaled by 10000. The term is |k|*65536*|c|/10000,
	// which equals |k|*4096*|c|/625; |k|*4096 is split into Q*625 + R.
	localparam int K_V_TO_R = 14020;
	localparam int K_U_TO_G = 3441;
	localparam int K_V_TO_G = 7141;
	localparam int K_U_TO_B = 17720;
	localparam int DIVISOR  = 625;

	localparam int QUOT_W = 17;
	localparam int REM_W  = 10;

	// floor(x / 625) for x below 2^17 is (x * RECIP) >> RECIP_SHIFT, exactly.
	localparam int RECIP_SHIFT = 32;
	localparam int RECIP_W     = 23;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT) + DIVISOR - 1)
		/ DIVISOR);

	localparam logic [QUOT_W-1:0] Q_V_TO_R = QUOT_W'((K_V_TO_R * 4096) / DIVISOR);
	localparam logic [QUOT_W-1:0] Q_U_TO_G = QUOT_W'((K_U_TO_G * 4096) / DIVISOR);
	localparam logic [QUOT_W-1:0] Q_V_TO_G = QUOT_W'((K_V_TO_G * 4096) / DIVISOR);
	localparam logic [QUOT_W-1:0] Q_U_TO_B = QUOT_W'((K_U_TO_B * 4096) / DIVISOR);
	localparam logic [REM_W-1:0]  R_V_TO_R = REM_W'((K_V_TO_R * 4096) % DIVISOR);
	localparam logic [REM_W-1:0]  R_U_TO_G = REM_W'((K_U_TO_G * 4096) % DIVISOR);
	localparam logic [REM_W-1:0]  R_V_TO_G = REM_W'((K_V_TO_G * 4096) % DIVISOR);
	localparam logic [REM_W-1:0]  R_U_TO_B = REM_W'((K_U_TO_B * 4096) % DIVISOR);

	function automatic logic [QUOT_W-1:0] coef_quot(input coef_t id);
		logic [QUOT_W-1:0] q;
		unique case (id)
			COEF_V_TO_R: q = Q_V_TO_R;
			COEF_U_TO_G: q = Q_U_TO_G;
			COEF_V_TO_G: q = Q_V_TO_G;
			COEF_U_TO_B: q = Q_U_TO_B;
			default:     q = '0;
		endcase
		return q;
	endfunction

	function automatic logic [REM_W-1:0] coef_rem(input coef_t id);
		logic [REM_W-1:0] r;
		unique case (id)
			COEF_V_TO_R: r = R_V_TO_R;
			COEF_U_TO_G: r = R_U_TO_G;
			COEF_V_TO_G: r = R_V_TO_G;
			COEF_U_TO_B: r = R_U_TO_B;
			default:     r = '0;
		endcase
		return r;
	endfunction

	// Both green coefficients are negative.
	function automatic logic coef_neg(input coef_t id);
		return (id == COEF_U_TO_G) || (id == COEF_V_TO_G);
	endfunction

endpackage

// ----- hdl/y2r_chroma_term.sv -----
// ----------------------------------------------------------------------------
// y2r_chroma_term: one chroma coefficient lane
// Computes trunc(k * 65536 * c / 10000) for a fixed coefficient over two
// pipeline stages, in sign and magnitude form.
// ----------------------------------------------------------------------------
module y2r_chroma_term (
	input  logic                              clk,
	input  y2r_pkg::stage_en_t                en,
	input  y2r_pkg::coef_t                    coef,
	input  logic signed [7:0]                 chroma,
	output logic signed [y2r_pkg::TERM_W-1:0] term
);

	localparam int QM_W   = y2r_pkg::TERM_W - 1;
	localparam int RM_W   = 17;
	localparam int PROD_W = RM_W + y2r_pkg::RECIP_W;

	logic [7:0]        chroma_u;
	logic [7:0]        mag;
	logic [QM_W-1:0]   qm_s1;
	logic [RM_W-1:0]   rm_s1;
	logic              neg_s1;
	logic [PROD_W-1:0] prod;
	logic [QM_W-1:0]   mag_sum;
	logic signed [y2r_pkg::TERM_W-1:0] term_s2;

	// Magnitude of the chroma sample; -128 maps to 128.
	always_comb begin
		chroma_u = unsigned'(chroma);
		mag      = chroma_u[7] ? (~chroma_u + 8'd1) : chroma_u;
	end

	// Stage 1: quotient and remainder partial products.
	always_ff @(posedge clk) begin
		if (en.s1) begin
			qm_s1  <= QM_W'(y2r_pkg::coef_quot(coef)) * QM_W'(mag);
			rm_s1  <= RM_W'(y2r_pkg::coef_rem(coef)) * RM_W'(mag);
			neg_s1 <= y2r_pkg::coef_neg(coef) ^ chroma_u[7];
		end
	end

	// Stage 2: divide the remainder product by 625 through the reciprocal.
	always_comb begin
		prod    = PROD_W'(rm_s1) * PROD_W'(y2r_pkg::RECIP);
		mag_sum = qm_s1 + QM_W'(prod[PROD_W-1:y2r_pkg::RECIP_SHIFT]);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			term_s2 <= neg_s1 ? -signed'({1'b0, mag_sum}) : signed'({1'b0, mag_sum});
		end
	end

	assign term = term_s2;

endmodule

// ----- hdl/y2r_pixel_lane.sv -----
// ----------------------------------------------------------------------------
// y2r_pixel_lane: one pixel conversion lane
// Adds the shared chroma terms to the scaled luma, floors by 2^16 and
// clamps each channel to 0..255.
// ----------------------------------------------------------------------------
module y2r_pixel_lane (
	input  logic                luma,
	input  logic [7:0]          luma_value,
	input  y2r_pkg::terms_t     terms,
	output y2r_pkg::rgb_t       rgb
);

	localparam int SUM_W = 27;

	logic signed [SUM_W-1:0] base;
	logic signed [SUM_W-1:0] sum_r;
	logic signed [SUM_W-1:0] sum_g;
	logic signed [SUM_W-1:0] sum_b;

	// Take the floor by dropping the fraction, then clamp.
	function automatic logic [7:0] clamp_chan(input logic signed [SUM_W-1:0] s);
		logic [SUM_W-17:0] whole;
		logic [7:0]        c;
		whole = s[SUM_W-1:16];
		if (whole[SUM_W-17]) begin
			c = 8'd0;
		end else if (whole[SUM_W-18:8] != '0) begin
			c = 8'd255;
		end else begin
			c = whole[7:0];
		end
		return c;
	endfunction

	always_comb begin
		base  = signed'({3'b000, luma_value, 16'h0000});
		sum_r = base + SUM_W'(terms.v_to_r);
		sum_g = base + SUM_W'(terms.u_to_g) + SUM_W'(terms.v_to_g);
		sum_b = base + SUM_W'(terms.u_to_b);
		rgb.red   = clamp_chan(sum_r);
		rgb.green = clamp_chan(sum_g);
		rgb.blue  = luma ? clamp_chan(sum_b) : clamp_chan(sum_b);
	end

endmodule

// ----- hdl/yuv422_pair_to_rgb_top.sv -----
// ----------------------------------------------------------------------------
// yuv422_pair_to_rgb_top: packed 4:2:2 pair to two RGB888 pixels
// Four chroma lanes share one chroma pair, two pixel lanes apply it to each
// luma, and a merging stage forms the output beat.
//
//   channel   valid        ready        payload
//   input     pair_valid   pair_ready   pair   (y2r_pkg::pair_t)
//   output    pixel_valid  pixel_ready  pixels (y2r_pkg::pixels_t)
//
// One beat per clock is accepted and delivered when the output is taken.
// The two chroma multiplier stages are followed by the lane adders, clamps and
// output register.
// Reset clears only the stage valid bits; no stored state survives a beat.
// A stall at the output fills the empty stages first, then holds pair_ready low.
// ----------------------------------------------------------------------------
module yuv422_pair_to_rgb_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pair_valid,
	output logic              pair_ready,
	input  y2r_pkg::pair_t    pair,
	output logic              pixel_valid,
	input  logic              pixel_ready,
	output y2r_pkg::pixels_t  pixels
);

	y2r_pkg::stage_en_t en;
	y2r_pkg::terms_t    terms;
	y2r_pkg::rgb_t      rgb_first;
	y2r_pkg::rgb_t      rgb_second;
	y2r_pkg::pixels_t   pixels_q;

	logic       v1_q;
	logic       v2_q;
	logic       v3_q;
	logic [7:0] luma_first_s1;
	logic [7:0] luma_second_s1;
	logic       present_s1;
	logic [7:0] luma_first_s2;
	logic [7:0] luma_second_s2;
	logic       present_s2;

	// A stage advances when it is empty or its successor advances.
	always_comb begin
		en.s3 = !v3_q || pixel_ready;
		en.s2 = !v2_q || en.s3;
		en.s1 = !v1_q || en.s2;
	end

	assign pair_ready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (en.s1) v1_q <= pair_valid;
			if (en.s2) v2_q <= v1_q;
			if (en.s3) v3_q <= v2_q;
		end
	end

	// Luma and presence ride alongside the chroma pipeline.
	always_ff @(posedge clk) begin
		if (en.s1) begin
			luma_first_s1  <= pair.luma_first;
			luma_second_s1 <= pair.luma_second;
			present_s1     <= pair.second_present;
		end
		if (en.s2) begin
			luma_first_s2  <= luma_first_s1;
			luma_second_s2 <= luma_second_s1;
			present_s2     <= present_s1;
		end
	end

	// Chroma coefficient lanes.
	y2r_chroma_term u_term_v_to_r (
		.clk(clk), .en(en), .coef(y2r_pkg::COEF_V_TO_R),
		.chroma(pair.chroma_red), .term(terms.v_to_r)
	);
	y2r_chroma_term u_term_u_to_g (
		.clk(clk), .en(en), .coef(y2r_pkg::COEF_U_TO_G),
		.chroma(pair.chroma_blue), .term(terms.u_to_g)
	);
	y2r_chroma_term u_term_v_to_g (
		.clk(clk), .en(en), .coef(y2r_pkg::COEF_V_TO_G),
		.chroma(pair.chroma_red), .term(terms.v_to_g)
	);
	y2r_chroma_term u_term_u_to_b (
		.clk(clk), .en(en), .coef(y2r_pkg::COEF_U_TO_B),
		.chroma(pair.chroma_blue), .term(terms.u_to_b)
	);

	// Pixel lanes.
	y2r_pixel_lane u_lane_first (
		.luma(1'b1), .luma_value(luma_first_s2), .terms(terms), .rgb(rgb_first)
	);
	y2r_pixel_lane u_lane_second (
		.luma(1'b1), .luma_value(luma_second_s2), .terms(terms), .rgb(rgb_second)
	);

	// Merge the lanes into the output beat; an absent second pixel reads zero.
	always_ff @(posedge clk) begin
		if (en.s3) begin
			pixels_q.red_first    <= rgb_first.red;
			pixels_q.green_first  <= rgb_first.green;
			pixels_q.blue_first   <= rgb_first.blue;
			pixels_q.red_second   <= present_s2 ? rgb_second.red : 8'd0;
			pixels_q.green_second <= present_s2 ? rgb_second.green : 8'd0;
			pixels_q.blue_second  <= present_s2 ? rgb_second.blue : 8'd0;
			pixels_q.second_valid <= present_s2;
		end
	end

	assign pixel_valid = v3_q;
	assign pixels      = pixels_q;

`ifndef SYNTHESIS
	// An empty output register never blocks the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_valid |-> pair_ready)
		else $error("input stalled while output register empty");

	// With every stage full and the output stalled, no beat may enter.
	assert property (@(posedge clk) disable iff (!arst_n)
		(v1_q && v2_q && pixel_valid && !pixel_ready) |-> !pair_ready)
		else $error("beat accepted into a full pipeline");

	// An absent second pixel is delivered as zeros.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && !pixels.second_valid) |->
		(pixels.red_second == 8'd0 && pixels.green_second == 8'd0 &&
		 pixels.blue_second == 8'd0))
		else $error("absent second pixel carries nonzero color");

	// A beat leaves the middle stage only into a free or draining output.
	assert property (@(posedge clk) disable iff (!arst_n)
		(v2_q && pixel_valid && !pixel_ready) |=> (v2_q && pixel_valid))
		else $error("beat lost while output stalled");
`endif

endmodule
